// File: rtl/sitp_pkg.sv
// ----------------------------------------------------------------------------
// sitp_pkg
// Shared types, constants and helpers of the signed integer text parser.
// ----------------------------------------------------------------------------
package sitp_pkg;

	localparam int MAX_CHARS = 1024;
	localparam int POS_W     = $clog2(MAX_CHARS);
	localparam int VALUE_W   = 64;
	localparam int OFFSET_W  = 10;

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_X_LO  = 8'h78;
	localparam logic [7:0] CH_X_UP  = 8'h58;
	localparam logic [7:0] CH_A_LO  = 8'h61;
	localparam logic [7:0] CH_F_LO  = 8'h66;
	localparam logic [7:0] CH_A_UP  = 8'h41;
	localparam logic [7:0] CH_F_UP  = 8'h46;

	localparam logic [4:0] RADIX_AUTO = 5'd0;
	localparam logic [4:0] RADIX_OCT  = 5'd8;
	localparam logic [4:0] RADIX_DEC  = 5'd10;
	localparam logic [4:0] RADIX_HEX  = 5'd16;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_BLANK,
		PH_PREFIX,
		PH_ZERO,
		PH_DIGITS,
		PH_DONE
	} phase_t;

	typedef struct packed {
		phase_t               phase;
		logic                 negative;
		logic [4:0]           radix;
		logic [VALUE_W-1:0]   acc;
		logic                 seen_digit;
		logic [POS_W-1:0]     pos;
	} parse_state_t;

	typedef struct packed {
		logic       ok;
		logic [3:0] val;
	} digit_t;

	function automatic digit_t digit_of(input logic [7:0] c);
		digit_t d;
		d.ok  = 1'b1;
		d.val = 4'd0;
		if (c >= CH_ZERO && c <= CH_NINE) begin
			d.val = 4'(c - CH_ZERO);
		end else if (c >= CH_A_LO && c <= CH_F_LO) begin
			d.val = 4'(c - CH_A_LO + 8'd10);
		end else if (c >= CH_A_UP && c <= CH_F_UP) begin
			d.val = 4'(c - CH_A_UP + 8'd10);
		end else begin
			d.ok = 1'b0;
		end
		return d;
	endfunction

endpackage

// File: rtl/sitp_step.sv
// ----------------------------------------------------------------------------
// sitp_step
// Next-state logic for one character: blank and sign handling, radix prefix
// resolution, digit accumulation and detection of the stopping character.
// ----------------------------------------------------------------------------
module sitp_step import sitp_pkg::*; (
	input  parse_state_t       cur,
	input  logic [7:0]         ch,
	input  logic               first,
	input  logic [4:0]         radix,
	output parse_state_t       nxt,
	output logic               emit,
	output logic [VALUE_W-1:0] value,
	output logic [OFFSET_W-1:0] end_offset,
	output logic               any_digits
);

	logic                     go;
	digit_t                   dig;
	logic [POS_W+OFFSET_W-1:0] pos_ext;

	always_comb begin
		nxt  = cur;
		emit = 1'b0;
		go   = 1'b1;
		dig  = digit_of(ch);

		if (first) begin
			nxt.negative   = 1'b0;
			nxt.radix      = radix;
			nxt.acc        = '0;
			nxt.seen_digit = 1'b0;
			nxt.pos        = '0;
			nxt.phase      = PH_BLANK;
		end else if (cur.phase == PH_IDLE || cur.phase == PH_DONE) begin
			go = 1'b0;
		end else if (cur.pos != POS_W'(MAX_CHARS - 1)) begin
			nxt.pos = cur.pos + POS_W'(1);
		end

		if (go && nxt.phase == PH_BLANK) begin
			if (ch == CH_SPACE || ch == CH_TAB) begin
				go = 1'b0;
			end else begin
				nxt.phase = PH_PREFIX;
				if (ch == CH_MINUS) begin
					nxt.negative = 1'b1;
					go = 1'b0;
				end else if (ch == CH_PLUS) begin
					go = 1'b0;
				end
			end
		end

		if (go && nxt.phase == PH_PREFIX) begin
			if (ch == CH_ZERO && (nxt.radix == RADIX_AUTO || nxt.radix == RADIX_HEX)) begin
				nxt.phase = PH_ZERO;
				go = 1'b0;
			end else begin
				if (nxt.radix == RADIX_AUTO) begin
					nxt.radix = RADIX_DEC;
				end
				nxt.phase = PH_DIGITS;
			end
		end

		// A character after a leading zero is either the x of a hex prefix or
		// the first real digit position; the zero itself counts as a digit.
		if (go && nxt.phase == PH_ZERO) begin
			if (ch == CH_X_LO || ch == CH_X_UP) begin
				nxt.radix = RADIX_HEX;
				nxt.phase = PH_DIGITS;
				go = 1'b0;
			end else begin
				nxt.seen_digit = 1'b1;
				nxt.acc        = '0;
				if (nxt.radix == RADIX_AUTO) begin
					nxt.radix = RADIX_OCT;
				end
				nxt.phase = PH_DIGITS;
			end
		end

		if (go) begin
			if (dig.ok && {1'b0, dig.val} < nxt.radix) begin
				nxt.acc        = nxt.acc * nxt.radix + VALUE_W'(dig.val);
				nxt.seen_digit = 1'b1;
			end else begin
				emit      = 1'b1;
				nxt.phase = PH_DONE;
			end
		end
	end

	assign value      = nxt.negative ? (VALUE_W'(0) - nxt.acc) : nxt.acc;
	assign pos_ext    = {{OFFSET_W{1'b0}}, nxt.pos};
	assign end_offset = pos_ext[OFFSET_W-1:0];
	assign any_digits = nxt.seen_digit;

endmodule

// File: rtl/signed_integer_text_parser.sv
// ----------------------------------------------------------------------------
// signed_integer_text_parser
// Streaming parser of signed integer text with radix detection.
// ----------------------------------------------------------------------------
// Characters enter one item per cycle unless stalled; an item flagged first
// starts a new string and samples its radix. Each item passes an input
// register, then the parse logic (a 64 by 5 bit multiply-add on the
// accumulator) into the result register, so the stopping character's result
// is registered before it is presented and the block sustains one character per
// clock unless stalled. Only the stopping character produces a result; items
// stall only while a result waits to be taken.
module signed_integer_text_parser import sitp_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       item_valid,
	output logic                       item_stall,
	input  logic [7:0]                 ch,
	input  logic                       first,
	input  logic [4:0]                 radix,
	output logic                       result_valid,
	input  logic                       result_stall,
	output logic signed [VALUE_W-1:0]  value,
	output logic [OFFSET_W-1:0]        end_offset,
	output logic                       any_digits
);

	logic                valid_s1;
	logic [7:0]          ch_s1;
	logic                first_s1;
	logic [4:0]          radix_s1;

	parse_state_t        st_q;
	parse_state_t        st_nxt;
	logic                emit;
	logic [VALUE_W-1:0]  value_nxt;
	logic [OFFSET_W-1:0] offset_nxt;
	logic                any_nxt;

	logic                out_valid_q;
	logic [VALUE_W-1:0]  value_q;
	logic [OFFSET_W-1:0] offset_q;
	logic                any_q;

	logic                advance;

	sitp_step u_step (
		.cur        (st_q),
		.ch         (ch_s1),
		.first      (first_s1),
		.radix      (radix_s1),
		.nxt        (st_nxt),
		.emit       (emit),
		.value      (value_nxt),
		.end_offset (offset_nxt),
		.any_digits (any_nxt)
	);

	// The staged character is processed once the result slot is free or is
	// being emptied in this cycle.
	assign advance    = valid_s1 && (!out_valid_q || !result_stall);
	assign item_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_valid && !item_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			ch_s1    <= ch;
			first_s1 <= first;
			radix_s1 <= radix;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.phase      <= PH_IDLE;
			st_q.negative   <= 1'b0;
			st_q.radix      <= '0;
			st_q.acc        <= '0;
			st_q.seen_digit <= 1'b0;
			st_q.pos        <= '0;
			out_valid_q     <= 1'b0;
		end else begin
			if (advance) begin
				st_q <= st_nxt;
			end
			if (advance && emit) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			value_q  <= value_nxt;
			offset_q <= offset_nxt;
			any_q    <= any_nxt;
		end
	end

	assign result_valid = out_valid_q;
	assign value        = value_q;
	assign end_offset   = offset_q;
	assign any_digits   = any_q;

`ifndef SYNTHESIS
	a_no_digit_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !any_q |-> value_q == '0)
		else $error("result without digits carries a nonzero value");

	a_idle_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.phase == PH_IDLE |-> !out_valid_q)
		else $error("result present before any string was started");

	a_digits_radix: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.phase == PH_DIGITS |-> st_q.radix != RADIX_AUTO)
		else $error("digit phase entered with unresolved radix");

	a_pos_sat: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.pos <= POS_W'(MAX_CHARS - 1))
		else $error("position counter passed its saturation limit");
`endif

endmodule
